// File: src/sgs_pkg.sv
// Shared types and constants for the scatter-gather segment splitter.
package sgs_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_e;

  localparam int unsigned PAGE_LOG2     = 12;
  localparam int unsigned PAGE_BYTES    = 4096;
  localparam int unsigned MAX_SEG_BYTES = 16384;
  localparam int unsigned MAX_RESULTS   = 37;
  localparam int unsigned BLK_LOG2_MIN  = 9;
  localparam int unsigned BLK_LOG2_MAX  = 12;
  localparam int unsigned SECTOR_LOG2   = 9;

  localparam logic [16:0] PIECES_MAX    = 17'h1FFFF;

endpackage

// File: src/sg_segment_splitter.sv
// Scatter-gather segment splitter: cuts segments at page and logical-block boundaries.
// The first piece passes through the input registers, the setup step and the output register.
// Throughput: one piece per cycle, while the output is not stalled, from a single shared
//   piece-cut unit; a segment goes through accept, setup and one cut step per piece.
// The next segment is accepted while the final piece still waits at the output.
// Reset: asynchronous, clears control state and counters; block size returns to 512.
module sg_segment_splitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        first_segment_i,
  input  logic        last_segment_i,
  input  logic [2:0]  start_sector_low_i,
  input  logic [24:0] request_bytes_i,
  input  logic [11:0] segment_count_i,
  input  logic [31:0] page_number_i,
  input  logic [15:0] seg_offset_i,
  input  logic [14:0] seg_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] piece_page_o,
  output logic [11:0] piece_offset_o,
  output logic [12:0] piece_length_o,
  output logic        ends_block_o,
  output logic        hole_seen_o,
  output logic        budget_error_o,
  output logic        last_piece_o
);

  sgs_pkg::state_e state_q, state_d;

  logic [3:0]  blk_log2_q;

  logic        first_q, last_q;
  logic [2:0]  ssec_q;
  logic [24:0] req_q;
  logic [11:0] nseg_q;
  logic [31:0] page_q;
  logic [15:0] soff_q;
  logic [14:0] slen_q;

  logic [14:0] len_q;
  logic        oversize_q;
  logic [14:0] pos_q;
  logic [12:0] bl_q;
  logic [16:0] pu_q;
  logic [17:0] budget_q;
  logic        hole_q;
  logic [5:0]  n_q;

  logic        out_valid_q;
  logic [31:0] piece_page_q;
  logic [11:0] piece_offset_q;
  logic [12:0] piece_length_q;
  logic        ends_block_q;
  logic        hole_seen_q;
  logic        budget_error_q;
  logic        last_piece_q;

  // control
  logic        out_free;
  logic        in_take;
  logic        setup_en;
  logic        load_piece;

  // block size
  logic [3:0]  lg;
  logic [12:0] bs;
  logic [12:0] bs_mask;

  // setup datapath
  logic [11:0] off_in_blk;
  logic [12:0] fs;
  logic [12:0] fs_lim;
  logic [12:0] bl_init;
  logic [25:0] req_round;
  logic [25:0] blocks;
  logic [17:0] budget_init;
  logic [14:0] len_init;
  logic        oversize_init;
  logic        hole_init;

  // piece-cut datapath
  logic [16:0] addr;
  logic [12:0] space;
  logic [12:0] left;
  logic [14:0] remain;
  logic [12:0] m1;
  logic [12:0] map;
  logic [12:0] left_after;
  logic        endb;
  logic [12:0] bl_next;
  logic [14:0] pos_next;
  logic [16:0] pu_next;
  logic [5:0]  n_next;
  logic        spent;
  logic        last_norm;
  logic        trunc;
  logic        run_done;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    if (blk_log2_q < 4'(sgs_pkg::BLK_LOG2_MIN)) begin
      lg = 4'(sgs_pkg::BLK_LOG2_MIN);
    end else if (blk_log2_q > 4'(sgs_pkg::BLK_LOG2_MAX)) begin
      lg = 4'(sgs_pkg::BLK_LOG2_MAX);
    end else begin
      lg = blk_log2_q;
    end
    bs      = 13'd1 << lg;
    bs_mask = bs - 13'd1;
  end

  always_comb begin
    off_in_blk    = {ssec_q, 9'd0} & bs_mask[11:0];
    fs            = (bs - {1'b0, off_in_blk}) & bs_mask;
    fs_lim        = (req_q < 25'(fs)) ? req_q[12:0] : fs;
    bl_init       = (fs_lim == 13'd0) ? bs : fs_lim;
    req_round     = 26'(req_q) + 26'(bs_mask);
    blocks        = req_round >> lg;
    budget_init   = {blocks[16:0], 1'b0} + 18'(nseg_q);
    oversize_init = slen_q > 15'(sgs_pkg::MAX_SEG_BYTES);
    len_init      = oversize_init ? 15'(sgs_pkg::MAX_SEG_BYTES) : slen_q;
    hole_init     = first_q ? 1'b0 : hole_q;
    if (!first_q && soff_q != 16'd0) begin
      hole_init = 1'b1;
    end
    if (!last_q && ((soff_q[11:0] + slen_q[11:0]) != 12'd0)) begin
      hole_init = 1'b1;
    end
  end

  always_comb begin
    addr       = 17'(soff_q) + 17'(pos_q);
    space      = 13'(sgs_pkg::PAGE_BYTES) - {1'b0, addr[11:0]};
    left       = (bl_q == 13'd0) ? bs : bl_q;
    remain     = len_q - pos_q;
    m1         = (15'(space) < remain) ? space : remain[12:0];
    map        = (left < m1) ? left : m1;
    left_after = left - map;
    endb       = left_after == 13'd0;
    bl_next    = endb ? bs : left_after;
    pos_next   = pos_q + 15'(map);
    pu_next    = (pu_q == sgs_pkg::PIECES_MAX) ? pu_q : pu_q + 17'd1;
    n_next     = n_q + 6'd1;
    spent      = {1'b0, pu_q} >= budget_q;
    last_norm  = (pos_next >= len_q) || ({1'b0, pu_next} >= budget_q)
                 || (n_next >= 6'(sgs_pkg::MAX_RESULTS));
    trunc      = oversize_q || (pos_next < len_q);
    run_done   = spent || last_norm;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sgs_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = sgs_pkg::ST_SETUP;
      end
      sgs_pkg::ST_SETUP: begin
        state_d = (slen_q == 15'd0) ? sgs_pkg::ST_IDLE : sgs_pkg::ST_RUN;
      end
      sgs_pkg::ST_RUN: begin
        if (out_free && run_done) state_d = sgs_pkg::ST_IDLE;
      end
      default: state_d = sgs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    in_take    = 1'b0;
    setup_en   = 1'b0;
    load_piece = 1'b0;
    case (state_q)
      sgs_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        in_take    = in_valid_i;
      end
      sgs_pkg::ST_SETUP: setup_en = 1'b1;
      sgs_pkg::ST_RUN:   load_piece = out_free;
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sgs_pkg::ST_IDLE;
      blk_log2_q  <= 4'(sgs_pkg::BLK_LOG2_MIN);
      bl_q        <= '0;
      pu_q        <= '0;
      budget_q    <= '0;
      hole_q      <= 1'b0;
      n_q         <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) blk_log2_q <= cfg_wdata_i;
      if (setup_en) begin
        if (first_q) begin
          bl_q     <= bl_init;
          budget_q <= budget_init;
          pu_q     <= '0;
        end
        hole_q <= hole_init;
        pos_q  <= '0;
        n_q    <= '0;
      end
      if (load_piece && !spent) begin
        bl_q  <= bl_next;
        pu_q  <= pu_next;
        pos_q <= pos_next;
        n_q   <= n_next;
      end
      if (load_piece) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      first_q <= first_segment_i;
      last_q  <= last_segment_i;
      ssec_q  <= start_sector_low_i;
      req_q   <= request_bytes_i;
      nseg_q  <= segment_count_i;
      page_q  <= page_number_i;
      soff_q  <= seg_offset_i;
      slen_q  <= seg_length_i;
    end
    if (setup_en) begin
      len_q      <= len_init;
      oversize_q <= oversize_init;
    end
    if (load_piece) begin
      hole_seen_q <= hole_q;
      if (spent) begin
        piece_page_q   <= page_q + 32'(soff_q[15:12]);
        piece_offset_q <= soff_q[11:0];
        piece_length_q <= '0;
        ends_block_q   <= 1'b0;
        budget_error_q <= 1'b1;
        last_piece_q   <= 1'b1;
      end else begin
        piece_page_q   <= page_q + 32'(addr[16:12]);
        piece_offset_q <= addr[11:0];
        piece_length_q <= map;
        ends_block_q   <= endb;
        budget_error_q <= last_norm && trunc;
        last_piece_q   <= last_norm;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign piece_page_o   = piece_page_q;
  assign piece_offset_o = piece_offset_q;
  assign piece_length_o = piece_length_q;
  assign ends_block_o   = ends_block_q;
  assign hole_seen_o    = hole_seen_q;
  assign budget_error_o = budget_error_q;
  assign last_piece_o   = last_piece_q;

endmodule
